### sv/swat_pkg.sv
// Package for the service whitelist table: types, codes and field widths.
package swat_pkg;

  localparam int KEY_W       = 25;
  localparam int CNT_W       = 13;
  localparam int ADDR_W      = 64;
  localparam int IN_TDATA_W  = 320;
  localparam int OUT_TDATA_W = 24;
  localparam int DEF_BUCKET_BITS = 10;
  localparam int DEF_WAYS        = 4;

  // Request opcodes.
  localparam logic [1:0] OP_CHECK  = 2'd0;
  localparam logic [1:0] OP_ADD    = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EXISTS    = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  // Access control answers.
  localparam logic [1:0] ACL_UNSET   = 2'd0;
  localparam logic [1:0] ACL_ALLOWED = 2'd1;
  localparam logic [1:0] ACL_DENIED  = 2'd2;

  // One stored entry, apart from its valid bit.
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [ADDR_W-1:0] svc_hi;
    logic [ADDR_W-1:0] svc_lo;
    logic [ADDR_W-1:0] cli_hi;
    logic [ADDR_W-1:0] cli_lo;
  } slot_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr;
    logic load;
    logic hash;
    logic addr;
    logic eval;
    logic commit;
  } swat_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_done;
    logic out_free;
  } swat_stat_t;

  // Address comparison: IPv4 compares only bits 31:0 of the low word.
  function automatic logic addr_same(input logic fam,
                                     input logic [ADDR_W-1:0] ah, input logic [ADDR_W-1:0] al,
                                     input logic [ADDR_W-1:0] bh, input logic [ADDR_W-1:0] bl);
    logic r;
    if (!fam) begin
      r = (al[31:0] == bl[31:0]);
    end else begin
      r = (ah == bh) && (al == bl);
    end
    return r;
  endfunction

endpackage

### sv/swat_ctrl.sv
// Controller state machine: table clearing after reset and the request sequence.
module swat_ctrl
  import swat_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  swat_stat_t stat,
  output swat_cmd_t  cmd,
  output logic       clearing
);

  typedef enum logic [6:0] {
    S_CLR  = 7'b0000001,
    S_IDLE = 7'b0000010,
    S_HASH = 7'b0000100,
    S_ADDR = 7'b0001000,
    S_READ = 7'b0010000,
    S_EVAL = 7'b0100000,
    S_FIN  = 7'b1000000
  } state_t;

  state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_CLR: begin
        cmd.clr = 1'b1;
        if (stat.clr_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_HASH;
        end
      end
      S_HASH: begin
        cmd.hash   = 1'b1;
        state_next = S_ADDR;
      end
      S_ADDR: begin
        cmd.addr   = 1'b1;
        state_next = S_READ;
      end
      S_READ: begin
        state_next = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLR;
      end
    endcase
  end

  assign in_ready = (state == S_IDLE);
  assign clearing = (state == S_CLR);

endmodule

### sv/swat_dp.sv
// Datapath: bucket hash, way memories, match logic, entry count and result register.
module swat_dp
  import swat_pkg::*;
#(
  parameter int BUCKET_BITS = DEF_BUCKET_BITS,
  parameter int WAYS        = DEF_WAYS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [31:0]            seed,
  input  logic [1:0]             in_opcode,
  input  logic [IN_TDATA_W-1:0]  in_data,
  input  swat_cmd_t              cmd,
  output swat_stat_t             stat,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [OUT_TDATA_W-1:0] out_data
);

  localparam int NB    = 1 << BUCKET_BITS;
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

  // Captured request.
  logic [1:0]        op;
  logic              fam;
  logic [KEY_W-1:0]  key;
  logic [ADDR_W-1:0] sh, sl, ch, cl;
  logic [31:0]       word;
  logic [15:0]       port;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op   <= in_opcode;
      fam  <= in_data[0];
      key  <= {in_data[0], in_data[8:1], in_data[24:9]};
      port <= in_data[24:9];
      sh   <= in_data[88:25];
      sl   <= in_data[152:89];
      ch   <= in_data[216:153];
      cl   <= in_data[280:217];
      word <= in_data[312:281];
    end
  end

  // Bucket hash over two stages, one constant multiplication each.
  logic [31:0]            h1;
  logic [31:0]            h2;
  logic [BUCKET_BITS-1:0] bucket;

  assign h2 = (h1 * 32'd131) ^ seed;

  always_ff @(posedge clk) begin
    if (cmd.hash) begin
      h1 <= (word * 32'd31) ^ {16'd0, port};
    end
    if (cmd.addr) begin
      bucket <= h2[BUCKET_BITS-1:0];
    end
  end

  // Clearing sweep counter over the buckets.
  logic [BUCKET_BITS:0] clr_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (cmd.clr && !clr_idx[BUCKET_BITS]) begin
      clr_idx <= clr_idx + 1'b1;
    end
  end

  assign stat.clr_done = clr_idx[BUCKET_BITS];

  // Decisions registered at evaluation.
  logic             svc_hit, cli_hit, has_free, has_exact;
  logic [WAY_W-1:0] free_way, exact_way;
  logic             add_ok, del_ok;

  assign add_ok = cmd.commit && (op == OP_ADD) && !has_exact && has_free;
  assign del_ok = cmd.commit && (op == OP_DELETE) && has_exact;

  // Way memories, one per way, all read at the bucket address.
  logic             vld_rd  [WAYS];
  slot_t            slot_rd [WAYS];

  for (genvar w = 0; w < WAYS; w++) begin : g_way
    logic  vmem [NB];
    slot_t smem [NB];
    logic  v_we;
    logic  v_wd;
    logic [BUCKET_BITS-1:0] v_wa;

    always_comb begin
      v_we = cmd.clr ||
             (add_ok && (free_way == WAY_W'(w))) ||
             (del_ok && (exact_way == WAY_W'(w)));
      v_wd = !cmd.clr && (op == OP_ADD);
      v_wa = cmd.clr ? clr_idx[BUCKET_BITS-1:0] : bucket;
    end

    always_ff @(posedge clk) begin
      if (v_we) begin
        vmem[v_wa] <= v_wd;
      end
      vld_rd[w] <= vmem[bucket];
    end

    always_ff @(posedge clk) begin
      if (add_ok && (free_way == WAY_W'(w))) begin
        smem[bucket] <= '{key: key, svc_hi: sh, svc_lo: sl, cli_hi: ch, cli_lo: cl};
      end
      slot_rd[w] <= smem[bucket];
    end
  end

  // Compare every way and pick the lowest free and lowest exact way.
  logic             e_svc, e_cli, e_free, e_exact;
  logic [WAY_W-1:0] e_free_way, e_exact_way;

  always_comb begin
    logic s_m, c_m;
    e_svc       = 1'b0;
    e_cli       = 1'b0;
    e_free      = 1'b0;
    e_exact     = 1'b0;
    e_free_way  = '0;
    e_exact_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      s_m = vld_rd[w] && (slot_rd[w].key == key) &&
            addr_same(fam, slot_rd[w].svc_hi, slot_rd[w].svc_lo, sh, sl);
      c_m = s_m && addr_same(fam, slot_rd[w].cli_hi, slot_rd[w].cli_lo, ch, cl);
      if (s_m) begin
        e_svc = 1'b1;
      end
      if (c_m) begin
        e_cli       = 1'b1;
        e_exact     = 1'b1;
        e_exact_way = WAY_W'(w);
      end
      if (!vld_rd[w]) begin
        e_free     = 1'b1;
        e_free_way = WAY_W'(w);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      svc_hit   <= e_svc;
      cli_hit   <= e_cli;
      has_free  <= e_free;
      has_exact <= e_exact;
      free_way  <= e_free_way;
      exact_way <= e_exact_way;
    end
  end

  // Stored entry count.
  logic [CNT_W-1:0] count, count_next;

  always_comb begin
    count_next = count;
    if (add_ok) begin
      count_next = count + 1'b1;
    end else if (del_ok && (count != '0)) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Result fields.
  logic [1:0] r_status, r_acl;

  always_comb begin
    r_status = ST_OK;
    r_acl    = ACL_UNSET;
    case (op)
      OP_CHECK: begin
        r_acl = !svc_hit ? ACL_UNSET : (cli_hit ? ACL_ALLOWED : ACL_DENIED);
      end
      OP_ADD: begin
        if (has_exact) begin
          r_status = ST_EXISTS;
        end else if (!has_free) begin
          r_status = ST_FULL;
        end
      end
      OP_DELETE: begin
        if (!has_exact) begin
          r_status = ST_NOT_FOUND;
        end
      end
      default: begin
        r_status = ST_OK;
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data <= {6'd0, count_next, (r_acl == ACL_DENIED), r_acl, r_status};
    end
  end

  assign stat.out_free = !out_valid || out_ready;

endmodule

### sv/service_whitelist_acl_table_core.sv
// Top level of the hashed service whitelist table.
//
//  channel  | signals                               | contents
//  s_axis   | s_tvalid s_tready s_tdata s_tuser     | one request, opcode in tuser
//  m_axis   | m_tvalid m_tready m_tdata             | one result per request
//  config   | cfg_we cfg_wdata                      | hash seed
//
// After acceptance a request passes through the hash, address, read, evaluate
// and finish states before its result is loaded, for the hash multiplications,
// the registered way-memory read and the compare; the next request can be
// accepted in the cycle after that load, so requests do not overlap.
// After reset a clearing pass over all 2**BUCKET_BITS buckets (1024 by default)
// empties the valid memories, and no request is taken during it.
// A result waiting on m_tready lets one more request in, which then holds in
// its last step until the output register is free.
module service_whitelist_acl_table_core
  import swat_pkg::*;
#(
  parameter int BUCKET_BITS = DEF_BUCKET_BITS,
  parameter int WAYS        = DEF_WAYS
) (
  input  logic                   clk,
  input  logic                   rst,
  // family, protocol, service_port, service_addr_high, service_addr_low,
  // client_addr_high, client_addr_low, hash_word
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // opcode
  input  logic [1:0]             s_tuser,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // status, acl_state, reject, entry_total
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic                   cfg_we,
  input  logic [31:0]            cfg_wdata
);

  swat_cmd_t  cmd;
  swat_stat_t stat;
  logic       clearing;
  logic [31:0] seed;

  // Hash seed register.
  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= '0;
    end else if (cfg_we) begin
      seed <= cfg_wdata;
    end
  end

  swat_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd),
    .clearing (clearing)
  );

  swat_dp #(
    .BUCKET_BITS (BUCKET_BITS),
    .WAYS        (WAYS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .seed      (seed),
    .in_opcode (s_tuser),
    .in_data   (s_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

`ifndef SYNTHESIS
  // No request is taken while the table is being cleared.
  a_no_req_in_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s_tready)
    else $error("request accepted during clearing");

  // A result is loaded only when the output register is free.
  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!m_tvalid || m_tready))
    else $error("result overwritten");

  // An accepted request gives no result before its pipeline has run.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !cmd.commit ##1 !cmd.commit ##1 !cmd.commit)
    else $error("result loaded too early");
`endif

endmodule

### sim/tb.sv
// Self-checking testbench for the hashed service whitelist table.
module tb;
  import swat_pkg::*;

  localparam int NSLOTS = 4096;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic [1:0]             s_tuser = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [31:0]            cfg_wdata = '0;

  // One expected result.
  typedef struct packed {
    logic [1:0]       status;
    logic [1:0]       acl;
    logic             rej;
    logic [CNT_W-1:0] total;
  } verdict_t;

  // Shadow copy of the table.
  logic              tbl_valid [NSLOTS];
  logic [KEY_W-1:0]  tbl_key   [NSLOTS];
  logic [63:0]       tbl_sh    [NSLOTS];
  logic [63:0]       tbl_sl    [NSLOTS];
  logic [63:0]       tbl_ch    [NSLOTS];
  logic [63:0]       tbl_cl    [NSLOTS];
  logic [CNT_W-1:0]  tbl_count;
  logic [31:0]       seed;

  verdict_t verdicts_due[$];
  int       errors = 0;
  int       burst_left = 0;
  int       hold_cycles = 0;

  // Pool of services, built so that several share one bucket.
  logic        pool_fam   [8];
  logic [7:0]  pool_proto [8];
  logic [15:0] pool_port  [8];
  logic [63:0] pool_sh    [8];
  logic [63:0] pool_sl    [8];
  logic [31:0] pool_hw    [8];
  logic [63:0] cli_h      [4];
  logic [63:0] cli_l      [4];

  service_whitelist_acl_table_core uut (
    .clk(clk), .rst(rst),
    .s_tdata(s_tdata), .s_tuser(s_tuser), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic logic same_addr(logic fam, logic [63:0] ah, logic [63:0] al,
                                     logic [63:0] bh, logic [63:0] bl);
    if (!fam) begin
      return al[31:0] == bl[31:0];
    end
    return (ah == bh) && (al == bl);
  endfunction

  // Works out the result of one accepted request and updates the shadow table.
  task automatic apply_request(logic [1:0] op, logic fam, logic [7:0] proto,
                               logic [15:0] port, logic [63:0] sh, logic [63:0] sl,
                               logic [63:0] ch, logic [63:0] cl, logic [31:0] hw);
    logic [31:0]      h;
    logic [KEY_W-1:0] key;
    int               base;
    int               exact;
    int               free_way;
    int               s;
    logic             svc_hit;
    logic             cli_hit;
    verdict_t         v;
    h = (((hw * 32'd31) ^ {16'd0, port}) * 32'd131) ^ seed;
    base = int'(h[9:0]) * 4;
    key = {fam, proto, port};
    exact = -1;
    free_way = -1;
    svc_hit = 1'b0;
    cli_hit = 1'b0;
    for (int w = 0; w < 4; w++) begin
      s = base + w;
      if (!tbl_valid[s]) begin
        if (free_way < 0) free_way = s;
      end else if (tbl_key[s] == key && same_addr(fam, tbl_sh[s], tbl_sl[s], sh, sl)) begin
        svc_hit = 1'b1;
        if (same_addr(fam, tbl_ch[s], tbl_cl[s], ch, cl)) begin
          cli_hit = 1'b1;
          if (exact < 0) exact = s;
        end
      end
    end
    v = '0;
    case (op)
      OP_CHECK: begin
        v.acl = !svc_hit ? ACL_UNSET : (cli_hit ? ACL_ALLOWED : ACL_DENIED);
      end
      OP_ADD: begin
        if (exact >= 0) begin
          v.status = ST_EXISTS;
        end else if (free_way < 0) begin
          v.status = ST_FULL;
        end else begin
          tbl_valid[free_way] = 1'b1;
          tbl_key[free_way] = key;
          tbl_sh[free_way] = sh;
          tbl_sl[free_way] = sl;
          tbl_ch[free_way] = ch;
          tbl_cl[free_way] = cl;
          tbl_count++;
        end
      end
      OP_DELETE: begin
        if (exact < 0) begin
          v.status = ST_NOT_FOUND;
        end else begin
          tbl_valid[exact] = 1'b0;
          if (tbl_count > 0) tbl_count--;
        end
      end
      default: ;
    endcase
    v.rej = (v.acl == ACL_DENIED);
    v.total = tbl_count;
    verdicts_due.push_back(v);
  endtask

  // Offers one request in bursts with random gaps and records its result on acceptance.
  task automatic send_request(logic [1:0] op, logic fam, logic [7:0] proto,
                              logic [15:0] port, logic [63:0] sh, logic [63:0] sl,
                              logic [63:0] ch, logic [63:0] cl, logic [31:0] hw);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        s_tvalid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    s_tuser = op;
    s_tdata = '0;
    s_tdata[312:0] = {hw, cl, ch, sl, sh, port, proto, fam};
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    apply_request(op, fam, proto, port, sh, sl, ch, cl, hw);
    @(negedge clk);
  endtask

  // Lowers the request valid and waits until every result has come back.
  task automatic drain;
    s_tvalid = 1'b0;
    while (verdicts_due.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_seed(logic [31:0] value);
    drain();
    cfg_wdata = value;
    cfg_we = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
    seed = value;
  endtask

  // Fresh pool: pairs of services share hash word and port so buckets collide.
  task automatic new_pool;
    for (int i = 0; i < 8; i++) begin
      pool_fam[i] = 1'($urandom_range(0, 1));
      pool_proto[i] = 8'($urandom);
      pool_port[i] = (i % 2) ? pool_port[i-1] : 16'($urandom);
      pool_hw[i] = (i % 2) ? pool_hw[i-1] : $urandom;
      pool_sh[i] = {$urandom, $urandom};
      pool_sl[i] = {$urandom, $urandom};
    end
    for (int i = 0; i < 4; i++) begin
      cli_h[i] = {$urandom, $urandom};
      cli_l[i] = {$urandom, $urandom};
    end
  endtask

  // One random request drawn mostly from the pool.
  task automatic send_random;
    int          p;
    int          c;
    int          r;
    logic [1:0]  op;
    logic [63:0] sh;
    logic [63:0] sl;
    logic [63:0] ch;
    logic [63:0] cl;
    p = $urandom_range(0, 7);
    c = $urandom_range(0, 3);
    r = $urandom_range(0, 99);
    op = (r < 40) ? OP_ADD : (r < 60) ? OP_DELETE : (r < 95) ? OP_CHECK : 2'd3;
    sh = pool_sh[p];
    sl = pool_sl[p];
    ch = cli_h[c];
    cl = cli_l[c];
    // IPv4 entries ignore the bits above 31, so vary them.
    if (!pool_fam[p] && $urandom_range(0, 1)) begin
      sh = {$urandom, $urandom};
      sl[63:32] = $urandom;
      ch = {$urandom, $urandom};
      cl[63:32] = $urandom;
    end
    if ($urandom_range(0, 9) == 0) begin
      ch = {$urandom, $urandom};
      cl = {$urandom, $urandom};
    end
    if ($urandom_range(0, 19) == 0) begin
      send_request(op, 1'($urandom), 8'($urandom), 16'($urandom), {$urandom, $urandom},
                   {$urandom, $urandom}, ch, cl, $urandom);
    end else begin
      send_request(op, pool_fam[p], pool_proto[p], pool_port[p], sh, sl, ch, cl,
                   pool_hw[p]);
    end
  endtask

  // Field extremes, every opcode and the listed corner cases.
  task automatic test_directed;
    logic [63:0] ones;
    ones = '1;
    send_request(OP_CHECK, 0, 0, 0, 0, 0, 0, 0, 0);
    send_request(OP_ADD, 0, 0, 0, 0, 0, 0, 0, 0);
    send_request(OP_ADD, 0, 0, 0, 0, 0, 0, 0, 0);
    send_request(OP_CHECK, 0, 0, 0, 0, 0, 0, 0, 0);
    send_request(OP_CHECK, 0, 0, 0, ones, {32'hFFFF_FFFF, 32'd0}, ones,
                 {32'hFFFF_FFFF, 32'd0}, 0);
    send_request(OP_CHECK, 0, 0, 0, 0, 0, 0, 1, 0);
    send_request(OP_ADD, 1, 8'hFF, 16'hFFFF, ones, ones, ones, ones, 32'hFFFF_FFFF);
    send_request(OP_CHECK, 1, 8'hFF, 16'hFFFF, ones, ones, ones, ones, 32'hFFFF_FFFF);
    send_request(OP_CHECK, 1, 8'hFF, 16'hFFFF, ones, ones, 0, ones, 32'hFFFF_FFFF);
    send_request(OP_CHECK, 1, 8'hFF, 16'hFFFF, 0, ones, ones, ones, 32'hFFFF_FFFF);
    send_request(2'd3, 1, 8'hFF, 16'hFFFF, ones, ones, ones, ones, 32'hFFFF_FFFF);
    send_request(OP_DELETE, 1, 8'hFF, 16'hFFFF, ones, ones, 0, 0, 32'hFFFF_FFFF);
    send_request(OP_DELETE, 1, 8'hFF, 16'hFFFF, ones, ones, ones, ones, 32'hFFFF_FFFF);
    send_request(OP_DELETE, 1, 8'hFF, 16'hFFFF, ones, ones, ones, ones, 32'hFFFF_FFFF);
    // Five clients of one service overflow its four-way bucket.
    for (int i = 0; i < 5; i++) begin
      send_request(OP_ADD, 1, 8'd6, 16'd80, 64'd7, 64'd9, 64'd0, 64'(i + 1), 32'h0A00_0001);
    end
    send_request(OP_CHECK, 1, 8'd6, 16'd80, 64'd7, 64'd9, 64'd0, 64'd5, 32'h0A00_0001);
    send_request(OP_DELETE, 1, 8'd6, 16'd80, 64'd7, 64'd9, 64'd0, 64'd2, 32'h0A00_0001);
    send_request(OP_ADD, 1, 8'd6, 16'd80, 64'd7, 64'd9, 64'd0, 64'd5, 32'h0A00_0001);
    send_request(OP_CHECK, 1, 8'd6, 16'd80, 64'd7, 64'd9, 64'd0, 64'd5, 32'h0A00_0001);
    drain();
  endtask

  // Random traffic under a given hash seed.
  task automatic test_random(logic [31:0] value, int count);
    write_seed(value);
    new_pool();
    repeat (count) send_random();
  endtask

  // Receiver holds off for a long stretch while requests keep coming.
  task automatic test_backpressure;
    drain();
    hold_cycles = 300;
    repeat (25) send_random();
    drain();
  endtask

  // Receiver stall pattern, with a long hold-off when requested.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      m_tready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      case (($time / 640) % 4)
        0: m_tready <= 1'b1;
        1: m_tready <= ($urandom_range(0, 9) > 2);
        2: m_tready <= ~m_tready;
        default: m_tready <= ($urandom_range(0, 9) > 6);
      endcase
    end
  end

  // Compares each delivered result with the oldest expectation.
  always @(posedge clk) begin
    verdict_t got;
    verdict_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[1:0], m_tdata[3:2], m_tdata[4], m_tdata[17:5]};
      if (verdicts_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected result %h", m_tdata);
      end else begin
        want = verdicts_due.pop_front();
        if (got.status !== want.status || got.acl !== want.acl ||
            got.rej !== want.rej || got.total !== want.total) begin
          errors++;
          if (errors <= 10) begin
            $display("Mismatch: status %0d/%0d acl %0d/%0d reject %0d/%0d total %0d/%0d",
                     want.status, got.status, want.acl, got.acl,
                     want.rej, got.rej, want.total, got.total);
          end
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("FAIL service_whitelist_acl_table_core");
    $finish;
  end

  initial begin
    for (int i = 0; i < NSLOTS; i++) tbl_valid[i] = 1'b0;
    tbl_count = '0;
    seed = '0;
    repeat (5) @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_random(32'h0000_0000, 100);
    test_backpressure();
    test_random(32'hFFFF_FFFF, 130);
    test_random($urandom, 130);
    test_random(32'h0000_0000, 130);
    drain();
    if (errors == 0) begin
      $display("PASS service_whitelist_acl_table_core");
    end else begin
      $display("FAIL service_whitelist_acl_table_core");
    end
    $finish;
  end

endmodule

### service_whitelist_acl_table_core.f
sv/swat_pkg.sv
sv/swat_ctrl.sv
sv/swat_dp.sv
sv/service_whitelist_acl_table_core.sv
sim/tb.sv
